[design/trpr_pkg.sv]
`default_nettype none

package trpr_pkg;

  // Default coordinate width, signed Q16.16.
  localparam int unsigned COORD_WIDTH_DEF = 32;

  // Width of one partial product operand in the pipelined multipliers.
  localparam int unsigned LIMB_W = 32;

  // Scale register: unsigned Q16.16, reset to 1.0.
  localparam int unsigned SCALE_W = 32;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 32'h0001_0000;

  // Two Q16 fractions are dropped from the squared root operand.
  localparam int unsigned FRAC_SHIFT = 32;

endpackage

`default_nettype wire

[design/triangle_planar_rest_coords_core.sv]
// Pipeline: edge stage, edge multiplier, sum stage, square multiplier, C stage, scale
//   multiplier, root search and output register, in that order.
// Throughput: one triangle per cycle. The whole pipeline advances together and holds only
//   while a finished result waits on the output; the root search takes one stage per bit.
// Reset: rst_ni clears all valid bits and loads scale_q with 1.0 (0x0001_0000).
`default_nettype none

module triangle_planar_rest_coords_core #(
  parameter int unsigned COORD_WIDTH = trpr_pkg::COORD_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Scale register write port, unsigned Q16.16.
  input  logic                             cfg_we_i,
  input  logic [trpr_pkg::SCALE_W-1:0]     cfg_wdata_i,
  // Triangle input. tdata: p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z
  // (each COORD_WIDTH bits, signed), zero padded to whole bytes.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [((9*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // Flattened result. tdata: corner1_u (COORD_WIDTH-1), corner2_u (COORD_WIDTH, signed),
  // corner2_v (COORD_WIDTH-1), zero padded to whole bytes. tuser: degenerate.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [((3*COORD_WIDTH-2+7)/8)*8-1:0] m_axis_tdata,
  output logic                             m_axis_tuser
);

  localparam int unsigned W       = COORD_WIDTH;
  localparam int unsigned EXW     = W + 1;              // raw edge difference
  localparam int unsigned QW      = 2 * W + 2;          // |e0|^2, |dot|, |cross component|
  localparam int unsigned SXW     = 2 * W + 3;          // signed sums of products
  localparam int unsigned XW      = 4 * W + 4;          // squared terms and C
  localparam int unsigned SW      = trpr_pkg::SCALE_W;
  localparam int unsigned S2W     = 2 * SW;
  localparam int unsigned P3W     = XW + S2W;
  localparam int unsigned RAW     = P3W - trpr_pkg::FRAC_SHIFT;
  localparam int unsigned OUT_TW  = ((3 * W - 2 + 7) / 8) * 8;
  localparam logic [S2W-1:0] SCALE_SQ_RESET =
    S2W'(trpr_pkg::SCALE_RESET) * S2W'(trpr_pkg::SCALE_RESET);

  // The pipeline moves as one: every stage loads when the output register is
  // free or its result is being taken in this cycle.
  logic adv;

  // ---------------------------------------------------------------------------
  // Scale register and its square. The square is registered from scale_q and follows it
  // in the next cycle, far less than the distance from the input to the multiplier that uses it.
  // ---------------------------------------------------------------------------
  logic [SW-1:0]  scale_q;
  logic [S2W-1:0] scale_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q    <= trpr_pkg::SCALE_RESET;
      scale_sq_q <= SCALE_SQ_RESET;
    end else begin
      if (cfg_we_i) begin
        scale_q <= cfg_wdata_i;
      end
      scale_sq_q <= S2W'(scale_q) * S2W'(scale_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Edge stage: e0 = p1 - p0 and e1 = p2 - p0 as sign and magnitude. The
  // magnitude of a difference of two COORD_WIDTH values fits COORD_WIDTH bits.
  // ---------------------------------------------------------------------------
  logic [W-1:0] pin [9];
  logic [W-1:0] e0m_d [3];
  logic [W-1:0] e1m_d [3];
  logic [2:0]   e0s_d, e1s_d;
  logic [W-1:0] e0m_q [3];
  logic [W-1:0] e1m_q [3];
  logic [2:0]   e0s_q, e1s_q;
  logic         e_vld_q;

  always_comb begin
    logic [EXW-1:0] d0, d1, n0, n1;
    for (int i = 0; i < 9; i++) begin
      pin[i] = s_axis_tdata[i*W +: W];
    end
    for (int i = 0; i < 3; i++) begin
      d0 = {pin[3+i][W-1], pin[3+i]} - {pin[i][W-1], pin[i]};
      d1 = {pin[6+i][W-1], pin[6+i]} - {pin[i][W-1], pin[i]};
      n0 = (~d0) + EXW'(1);
      n1 = (~d1) + EXW'(1);
      e0s_d[i] = d0[W];
      e1s_d[i] = d1[W];
      e0m_d[i] = d0[W] ? n0[W-1:0] : d0[W-1:0];
      e1m_d[i] = d1[W] ? n1[W-1:0] : d1[W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else if (adv) begin
      e_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e0s_q <= e0s_d;
      e1s_q <= e1s_d;
      for (int i = 0; i < 3; i++) begin
        e0m_q[i] <= e0m_d[i];
        e1m_q[i] <= e1m_d[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // First products, twelve lanes: e0 squares (lanes 0-2), the dot product
  // terms (lanes 3-5), and the two terms of each cross product component
  // (lanes 6+2i and 7+2i). Signs ride along beside the magnitudes.
  // ---------------------------------------------------------------------------
  logic [W-1:0]   m1_a [12];
  logic [W-1:0]   m1_b [12];
  logic [2*W-1:0] m1_p [12];
  logic [5:0]     m1_side;
  logic           m1_vld;

  always_comb begin
    int j, k;
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      k = (i + 2) % 3;
      m1_a[i]       = e0m_q[i];
      m1_b[i]       = e0m_q[i];
      m1_a[3+i]     = e0m_q[i];
      m1_b[3+i]     = e1m_q[i];
      m1_a[6+2*i]   = e0m_q[j];
      m1_b[6+2*i]   = e1m_q[k];
      m1_a[7+2*i]   = e0m_q[k];
      m1_b[7+2*i]   = e1m_q[j];
    end
  end

  trpr_mul #(
    .N     (12),
    .AW    (W),
    .BW    (W),
    .SIDEW (6)
  ) u_mul_edge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (e_vld_q),
    .a_i    (m1_a),
    .b_i    (m1_b),
    .side_i ({e1s_q, e0s_q}),
    .vld_o  (m1_vld),
    .p_o    (m1_p),
    .side_o (m1_side)
  );

  // ---------------------------------------------------------------------------
  // Sum stage: |e0|^2, the dot product and the cross product components.
  // ---------------------------------------------------------------------------
  logic [2:0]              m1_e0s, m1_e1s;
  logic signed [SXW-1:0]   trm [3:11];
  logic signed [SXW-1:0]   dot;
  logic signed [SXW-1:0]   crs [3];
  logic [QW-1:0]           s2_q0_d, s2_dmag_d;
  logic [QW-1:0]           s2_crm_d [3];
  logic [QW-1:0]           s2_q0_q, s2_dmag_q;
  logic [QW-1:0]           s2_crm_q [3];
  logic                    s2_dsgn_q;
  logic                    s2_vld_q;

  assign m1_e0s = m1_side[2:0];
  assign m1_e1s = m1_side[5:3];

  always_comb begin
    int j, k;
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      k = (i + 2) % 3;
      trm[3+i]   = (m1_e0s[i] ^ m1_e1s[i]) ? -$signed(SXW'(m1_p[3+i]))
                                           :  $signed(SXW'(m1_p[3+i]));
      trm[6+2*i] = (m1_e0s[j] ^ m1_e1s[k]) ? -$signed(SXW'(m1_p[6+2*i]))
                                           :  $signed(SXW'(m1_p[6+2*i]));
      trm[7+2*i] = (m1_e0s[k] ^ m1_e1s[j]) ? -$signed(SXW'(m1_p[7+2*i]))
                                           :  $signed(SXW'(m1_p[7+2*i]));
    end
    dot = trm[3] + trm[4] + trm[5];
    for (int i = 0; i < 3; i++) begin
      crs[i]      = trm[6+2*i] - trm[7+2*i];
      s2_crm_d[i] = crs[i][SXW-1] ? QW'(-crs[i]) : QW'(crs[i]);
    end
    s2_dmag_d = dot[SXW-1] ? QW'(-dot) : QW'(dot);
    s2_q0_d   = QW'(m1_p[0]) + QW'(m1_p[1]) + QW'(m1_p[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s2_vld_q <= m1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_q0_q   <= s2_q0_d;
      s2_dmag_q <= s2_dmag_d;
      s2_dsgn_q <= dot[SXW-1];
      for (int i = 0; i < 3; i++) begin
        s2_crm_q[i] <= s2_crm_d[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Squares: the dot product (lane 0) and each cross component (lanes 1-3).
  // ---------------------------------------------------------------------------
  logic [QW-1:0] m2_a [4];
  logic [XW-1:0] m2_p [4];
  logic [QW:0]   m2_side;
  logic          m2_vld;

  always_comb begin
    m2_a[0] = s2_dmag_q;
    for (int i = 0; i < 3; i++) begin
      m2_a[1+i] = s2_crm_q[i];
    end
  end

  trpr_mul #(
    .N     (4),
    .AW    (QW),
    .BW    (QW),
    .SIDEW (QW + 1)
  ) u_mul_sq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (s2_vld_q),
    .a_i    (m2_a),
    .b_i    (m2_a),
    .side_i ({s2_q0_q, s2_dsgn_q}),
    .vld_o  (m2_vld),
    .p_o    (m2_p),
    .side_o (m2_side)
  );

  // ---------------------------------------------------------------------------
  // C = |e0 x e1|^2, and the zero-length edge check.
  // ---------------------------------------------------------------------------
  logic [QW-1:0] m2_q0;
  logic [XW-1:0] s3_x_q [3];
  logic [QW-1:0] s3_q0_q;
  logic          s3_dsgn_q, s3_deg_q;
  logic          s3_vld_q;

  assign m2_q0 = m2_side[QW:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (adv) begin
      s3_vld_q <= m2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_x_q[0] <= XW'(m2_q0);
      s3_x_q[1] <= m2_p[0];
      s3_x_q[2] <= m2_p[1] + m2_p[2] + m2_p[3];
      s3_q0_q   <= m2_q0;
      s3_dsgn_q <= m2_side[0];
      s3_deg_q  <= (m2_q0 == '0);
    end
  end

  // ---------------------------------------------------------------------------
  // Multiply |e0|^2, dot^2 and C by scale^2.
  // ---------------------------------------------------------------------------
  logic [S2W-1:0] m3_b [3];
  logic [P3W-1:0] m3_p [3];
  logic [QW+1:0]  m3_side;
  logic           m3_vld;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m3_b[i] = scale_sq_q;
    end
  end

  trpr_mul #(
    .N     (3),
    .AW    (XW),
    .BW    (S2W),
    .SIDEW (QW + 2)
  ) u_mul_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (s3_vld_q),
    .a_i    (s3_x_q),
    .b_i    (m3_b),
    .side_i ({s3_q0_q, s3_dsgn_q, s3_deg_q}),
    .vld_o  (m3_vld),
    .p_o    (m3_p),
    .side_o (m3_side)
  );

  // ---------------------------------------------------------------------------
  // Root search. Every coordinate is the largest r with r^2 * y <= a, where
  // the Q16 scaling has already been folded into a:
  //   corner1_u: a = |e0|^2 S^2 / 2^32,  y = 1
  //   corner2_u: a = dot^2 S^2 / 2^32,   y = |e0|^2
  //   corner2_v: a = C S^2 / 2^32,       y = |e0|^2
  // The search covers COORD_WIDTH bits, enough to detect saturation.
  // ---------------------------------------------------------------------------
  logic [RAW-1:0] rt_a [3];
  logic [QW-1:0]  rt_y [3];
  logic [W-1:0]   rt_r [3];
  logic [1:0]     rt_side;
  logic           rt_vld;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rt_a[i] = m3_p[i][P3W-1:trpr_pkg::FRAC_SHIFT];
    end
    rt_y[0] = QW'(1);
    rt_y[1] = m3_side[QW+1:2];
    rt_y[2] = m3_side[QW+1:2];
  end

  trpr_root #(
    .N     (3),
    .AW    (RAW),
    .YW    (QW),
    .RW    (W),
    .SIDEW (2)
  ) u_root (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (m3_vld),
    .a_i    (rt_a),
    .y_i    (rt_y),
    .side_i (m3_side[1:0]),
    .vld_o  (rt_vld),
    .r_o    (rt_r),
    .side_o (rt_side)
  );

  // ---------------------------------------------------------------------------
  // Output register: saturation, sign and the degenerate override.
  // A negative corner2_u saturates at -2^(W-1); the positive fields at
  // 2^(W-1)-1.
  // ---------------------------------------------------------------------------
  logic         rt_dsgn, rt_deg;
  logic [W-2:0] c1u_d, c2v_d;
  logic [W-1:0] c2u_d;
  logic [W-2:0] m_c1u_q, m_c2v_q;
  logic [W-1:0] m_c2u_q;
  logic         m_deg_q;
  logic         m_vld_q;

  assign rt_dsgn = rt_side[1];
  assign rt_deg  = rt_side[0];

  always_comb begin
    c1u_d = rt_r[0][W-1] ? '1 : rt_r[0][W-2:0];
    c2v_d = rt_r[2][W-1] ? '1 : rt_r[2][W-2:0];
    if (rt_dsgn) begin
      c2u_d = rt_r[1][W-1] ? {1'b1, {(W-1){1'b0}}} : (~{1'b0, rt_r[1][W-2:0]}) + W'(1);
    end else begin
      c2u_d = rt_r[1][W-1] ? {1'b0, {(W-1){1'b1}}} : {1'b0, rt_r[1][W-2:0]};
    end
    if (rt_deg) begin
      c1u_d = '0;
      c2u_d = '0;
      c2v_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (adv) begin
      m_vld_q <= rt_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_c1u_q <= c1u_d;
      m_c2u_q <= c2u_d;
      m_c2v_q <= c2v_d;
      m_deg_q <= rt_deg;
    end
  end

  assign adv           = !m_vld_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = OUT_TW'({m_c2v_q, m_c2u_q, m_c1u_q});
  assign m_axis_tuser  = m_deg_q;

`ifndef SYNTHESIS
  // A degenerate triangle leaves all three coordinates at zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_vld_q && m_deg_q |-> (m_c1u_q == '0) && (m_c2u_q == '0) && (m_c2v_q == '0))
    else $error("degenerate result with nonzero coordinates");

  // With e0 of zero length, the dot product and the cross product must vanish.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_vld_q && (s2_q0_q == '0) |-> (s2_dmag_q == '0) && (s2_crm_q[0] == '0) &&
                                    (s2_crm_q[1] == '0) && (s2_crm_q[2] == '0))
    else $error("zero-length edge with nonzero dot or cross product");
`endif

endmodule

`default_nettype wire

[design/trpr_mul.sv]
`default_nettype none

// Lane-parallel pipelined unsigned multiplier. Each stage adds one limb by limb
// partial product per lane, so a product takes one stage per limb pair.
module trpr_mul #(
  parameter int unsigned N     = 1,
  parameter int unsigned AW    = 32,
  parameter int unsigned BW    = 32,
  parameter int unsigned SIDEW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [AW-1:0]    a_i [N],
  input  logic [BW-1:0]    b_i [N],
  input  logic [SIDEW-1:0] side_i,
  output logic             vld_o,
  output logic [AW+BW-1:0] p_o [N],
  output logic [SIDEW-1:0] side_o
);

  localparam int unsigned LW  = trpr_pkg::LIMB_W;
  localparam int unsigned NA  = (AW + LW - 1) / LW;
  localparam int unsigned NB  = (BW + LW - 1) / LW;
  localparam int unsigned NS  = NA * NB;
  localparam int unsigned PW  = AW + BW;
  localparam int unsigned AXW = NA * LW;
  localparam int unsigned BXW = NB * LW;

  logic             vld_q  [NS];
  logic [AXW-1:0]   a_q    [NS][N];
  logic [BXW-1:0]   b_q    [NS][N];
  logic [PW-1:0]    acc_q  [NS][N];
  logic [SIDEW-1:0] side_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam int unsigned IA = k / NB;
    localparam int unsigned IB = k % NB;
    localparam int unsigned SH = LW * (IA + IB);

    logic             vld_in;
    logic [SIDEW-1:0] side_in;
    logic [AXW-1:0]   a_in   [N];
    logic [BXW-1:0]   b_in   [N];
    logic [PW-1:0]    acc_in [N];
    logic [2*LW-1:0]  pp     [N];
    logic [PW-1:0]    acc_d  [N];

    if (k == 0) begin : g_first
      always_comb begin
        vld_in  = vld_i;
        side_in = side_i;
        for (int l = 0; l < N; l++) begin
          a_in[l]   = AXW'(a_i[l]);
          b_in[l]   = BXW'(b_i[l]);
          acc_in[l] = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        vld_in  = vld_q[k-1];
        side_in = side_q[k-1];
        for (int l = 0; l < N; l++) begin
          a_in[l]   = a_q[k-1][l];
          b_in[l]   = b_q[k-1][l];
          acc_in[l] = acc_q[k-1][l];
        end
      end
    end

    always_comb begin
      for (int l = 0; l < N; l++) begin
        pp[l]    = a_in[l][IA*LW +: LW] * b_in[l][IB*LW +: LW];
        acc_d[l] = acc_in[l] + (PW'(pp[l]) << SH);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= side_in;
        for (int l = 0; l < N; l++) begin
          a_q[k][l]   <= a_in[l];
          b_q[k][l]   <= b_in[l];
          acc_q[k][l] <= acc_d[l];
        end
      end
    end
  end

  assign vld_o  = vld_q[NS-1];
  assign side_o = side_q[NS-1];
  for (genvar l = 0; l < N; l++) begin : g_out
    assign p_o[l] = acc_q[NS-1][l];
  end

endmodule

`default_nettype wire

[design/trpr_root.sv]
`default_nettype none

// Lane-parallel pipelined root search. Stage j settles result bit RW-1-j:
// the largest r with r*r*y <= a, kept below 2^RW. The running r*r*y and r*y
// are carried along, so each stage needs only shifts, three adds and a compare.
module trpr_root #(
  parameter int unsigned N     = 1,
  parameter int unsigned AW    = 64,
  parameter int unsigned YW    = 32,
  parameter int unsigned RW    = 32,
  parameter int unsigned SIDEW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [AW-1:0]    a_i [N],
  input  logic [YW-1:0]    y_i [N],
  input  logic [SIDEW-1:0] side_i,
  output logic             vld_o,
  output logic [RW-1:0]    r_o [N],
  output logic [SIDEW-1:0] side_o
);

  localparam int unsigned PRODW = 2 * RW + YW;
  localparam int unsigned CW    = ((AW > PRODW) ? AW : PRODW) + 2;

  logic             vld_q  [RW];
  logic [AW-1:0]    a_q    [RW][N];
  logic [YW-1:0]    y_q    [RW][N];
  logic [CW-1:0]    sq_q   [RW][N];
  logic [CW-1:0]    p_q    [RW][N];
  logic [RW-1:0]    r_q    [RW][N];
  logic [SIDEW-1:0] side_q [RW];

  for (genvar j = 0; j < RW; j++) begin : g_stage
    localparam int unsigned I = RW - 1 - j;

    logic             vld_in;
    logic [SIDEW-1:0] side_in;
    logic [AW-1:0]    a_in  [N];
    logic [YW-1:0]    y_in  [N];
    logic [CW-1:0]    sq_in [N];
    logic [CW-1:0]    p_in  [N];
    logic [RW-1:0]    r_in  [N];
    logic [CW-1:0]    cand  [N];
    logic             take  [N];
    logic [CW-1:0]    sq_d  [N];
    logic [CW-1:0]    p_d   [N];
    logic [RW-1:0]    r_d   [N];

    if (j == 0) begin : g_first
      always_comb begin
        vld_in  = vld_i;
        side_in = side_i;
        for (int l = 0; l < N; l++) begin
          a_in[l]  = a_i[l];
          y_in[l]  = y_i[l];
          sq_in[l] = '0;
          p_in[l]  = '0;
          r_in[l]  = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        vld_in  = vld_q[j-1];
        side_in = side_q[j-1];
        for (int l = 0; l < N; l++) begin
          a_in[l]  = a_q[j-1][l];
          y_in[l]  = y_q[j-1][l];
          sq_in[l] = sq_q[j-1][l];
          p_in[l]  = p_q[j-1][l];
          r_in[l]  = r_q[j-1][l];
        end
      end
    end

    // (r + 2^I)^2 * y = r^2*y + 2^(I+1)*r*y + 2^(2I)*y
    always_comb begin
      for (int l = 0; l < N; l++) begin
        cand[l] = sq_in[l] + (p_in[l] << (I + 1)) + (CW'(y_in[l]) << (2 * I));
        take[l] = (cand[l] <= CW'(a_in[l]));
        sq_d[l] = take[l] ? cand[l] : sq_in[l];
        p_d[l]  = take[l] ? (p_in[l] + (CW'(y_in[l]) << I)) : p_in[l];
        r_d[l]  = r_in[l];
        r_d[l][I] = take[l];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[j] <= side_in;
        for (int l = 0; l < N; l++) begin
          a_q[j][l]  <= a_in[l];
          y_q[j][l]  <= y_in[l];
          sq_q[j][l] <= sq_d[l];
          p_q[j][l]  <= p_d[l];
          r_q[j][l]  <= r_d[l];
        end
      end
    end
  end

  assign vld_o  = vld_q[RW-1];
  assign side_o = side_q[RW-1];
  for (genvar l = 0; l < N; l++) begin : g_out
    assign r_o[l] = r_q[RW-1][l];
  end

endmodule

`default_nettype wire

[tb/tb_top.sv]
`default_nettype none

// Self-checking bench for the triangle flattening core. A driver feeds
// triangles from a queue, a monitor checks each flattened result against a
// predictor that works in exact wide integer arithmetic.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CW = trpr_pkg::COORD_WIDTH_DEF;
  localparam int unsigned IN_W = ((9 * CW + 7) / 8) * 8;
  localparam int unsigned OUT_W = ((3 * CW - 2 + 7) / 8) * 8;
  // Wait after the queues run empty, with margin over the pipeline depth of the core.
  localparam int unsigned DRAIN_CYCLES = 80;

  typedef logic signed [CW-1:0] coord_t;
  typedef struct {
    coord_t pt[9];  // p0 xyz, p1 xyz, p2 xyz
  } triangle_t;
  typedef struct {
    logic [CW-2:0] c1u;
    logic [CW-1:0] c2u;
    logic [CW-2:0] c2v;
    logic          degen;
  } flat_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [trpr_pkg::SCALE_W-1:0] cfg_wdata_i = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;
  logic              m_axis_tuser;

  triangle_planar_rest_coords_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  triangle_t  pending_tris[$];
  flat_t      expected_flats[$];
  logic [31:0] scale_copy = trpr_pkg::SCALE_RESET;
  bit         quiet = 1'b0;  // no idling on either side near the end
  int         n_errors = 0;
  int         n_checked = 0;
  int         n_degen = 0;
  int         n_sat = 0;

  // Floor of the square root, bit by bit.
  function automatic logic [255:0] isqrt256(input logic [255:0] a);
    logic [255:0] r;
    logic [255:0] b;
    r = '0;
    b = 256'd1 << 254;
    while (b > a) b = b >> 2;
    while (b != 0) begin
      if (a >= r + b) begin
        a = a - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic flat_t flatten_triangle(input triangle_t t, input logic [31:0] scale);
    logic signed [CW+1:0] e0[3];
    logic signed [CW+1:0] e1[3];
    logic signed [2*CW+7:0] dot;
    logic signed [2*CW+7:0] cr;
    logic [255:0] q0, crsq, dmag, sc, sq, val;
    logic [255:0] umax;
    flat_t f;
    int j, k;
    q0 = '0;
    dot = '0;
    crsq = '0;
    umax = (256'd1 << (CW - 1)) - 1;
    for (int i = 0; i < 3; i++) begin
      e0[i] = (CW+2)'(t.pt[3+i]) - (CW+2)'(t.pt[i]);
      e1[i] = (CW+2)'(t.pt[6+i]) - (CW+2)'(t.pt[i]);
    end
    for (int i = 0; i < 3; i++) begin
      q0 = q0 + 256'((2*CW+8)'(e0[i]) * (2*CW+8)'(e0[i]));
      dot = dot + (2*CW+8)'(e0[i]) * (2*CW+8)'(e1[i]);
    end
    f = '{c1u: '0, c2u: '0, c2v: '0, degen: 1'b0};
    if (q0 == 0) begin
      f.degen = 1'b1;
      return f;
    end
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      k = (i + 2) % 3;
      cr = (2*CW+8)'(e0[j]) * (2*CW+8)'(e1[k]) - (2*CW+8)'(e0[k]) * (2*CW+8)'(e1[j]);
      if (cr < 0) cr = -cr;
      crsq = crsq + 256'(cr) * 256'(cr);
    end
    sc = 256'(scale);
    sq = sc * sc;
    val = isqrt256(q0 * sq) >> 16;
    f.c1u = (val > umax) ? umax[CW-2:0] : val[CW-2:0];
    dmag = (dot < 0) ? 256'(-dot) : 256'(dot);
    dmag = dmag * sc;
    val = isqrt256((dmag * dmag) / (q0 << 32));
    if (dot < 0) begin
      if (val > umax + 1) val = umax + 1;
      f.c2u = -val[CW-1:0];
    end else begin
      f.c2u = (val > umax) ? umax[CW-1:0] : val[CW-1:0];
    end
    val = isqrt256((crsq * sq) / (q0 << 32));
    f.c2v = (val > umax) ? umax[CW-2:0] : val[CW-2:0];
    return f;
  endfunction

  // Driver: presents pending triangles, with random idle bursts.
  triangle_t       in_flight;
  logic [IN_W-1:0] next_tdata;
  int              send_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        expected_flats = {expected_flats, flatten_triangle(in_flight, scale_copy)};
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_tris.size() > 0) begin
          in_flight = pending_tris.pop_front();
          next_tdata = '0;
          for (int i = 0; i < 9; i++) next_tdata[i*CW +: CW] = in_flight.pt[i];
          s_axis_tdata <= next_tdata;
          s_axis_tvalid <= 1'b1;
          if (!quiet && $urandom_range(0, 12) == 0) send_gap = $urandom_range(1, 19);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random backpressure bursts and the field by field check.
  int    stall_left = 0;
  flat_t got, want;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.c1u = m_axis_tdata[CW-2:0];
        got.c2u = m_axis_tdata[2*CW-2:CW-1];
        got.c2v = m_axis_tdata[3*CW-3:2*CW-1];
        got.degen = m_axis_tuser;
        if (expected_flats.size() == 0) begin
          $error("unexpected result transfer");
          n_errors++;
        end else begin
          want = expected_flats.pop_front();
          n_checked++;
          if (want.degen) n_degen++;
          if (want.c1u == '1 || want.c2v == '1) n_sat++;
          if (got.c1u !== want.c1u) begin
            $error("corner1_u expected %0d actual %0d", want.c1u, got.c1u);
            n_errors++;
          end
          if (got.c2u !== want.c2u) begin
            $error("corner2_u expected %0d actual %0d", $signed(want.c2u), $signed(got.c2u));
            n_errors++;
          end
          if (got.c2v !== want.c2v) begin
            $error("corner2_v expected %0d actual %0d", want.c2v, got.c2v);
            n_errors++;
          end
          if (got.degen !== want.degen) begin
            $error("degenerate expected %0d actual %0d", want.degen, got.degen);
            n_errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 12) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic coord_t rand_coord(input int mode, input coord_t base);
    case (mode)
      0: return coord_t'($urandom);
      1: return base + coord_t'($urandom_range(0, 2 * 65536)) - coord_t'(65536);
      2: return base + coord_t'($urandom_range(0, 255)) - coord_t'(128);
      default: return coord_t'($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000);
    endcase
  endfunction

  // Well-formed triangles around a common center, with some raw noise, some extreme
  // corner values and some collapsed first edges mixed in.
  task automatic queue_random(input int count);
    triangle_t t;
    coord_t base;
    int mode;
    for (int n = 0; n < count; n++) begin
      mode = $urandom_range(0, 9);
      base = coord_t'($urandom);
      for (int i = 0; i < 9; i++) begin
        if (mode < 2) t.pt[i] = rand_coord(0, base);
        else if (mode < 7) t.pt[i] = rand_coord(1, coord_t'(base >>> 2));
        else if (mode < 9) t.pt[i] = rand_coord(2, coord_t'(base >>> 8));
        else t.pt[i] = rand_coord(3, base);
      end
      if ($urandom_range(0, 15) == 0)
        for (int i = 0; i < 3; i++) t.pt[3+i] = t.pt[i];
      pending_tris = {pending_tris, t};
    end
  endtask

  task automatic write_scale(input logic [31:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    scale_copy = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Holds off until every queued triangle has been flattened and checked.
  task automatic wait_drained();
    while (!(pending_tris.size() == 0 && !s_axis_tvalid && expected_flats.size() == 0))
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic queue_tri(input coord_t a[9]);
    triangle_t t;
    t.pt = a;
    pending_tris = {pending_tris, t};
  endtask

  localparam coord_t CMAX = coord_t'(32'h7FFF_FFFF);
  localparam coord_t CMIN = coord_t'(32'h8000_0000);
  localparam coord_t ONE = coord_t'(32'h0001_0000);

  logic [31:0] scales[6];
  initial begin
    scales = '{32'h0001_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
               32'h0000_8000, 32'h0004_0000};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed triangles under the reset scale of 1.0.
    queue_tri('{0, 0, 0, 0, 0, 0, 0, 0, 0});
    queue_tri('{ONE, ONE, ONE, ONE, ONE, ONE, CMAX, CMIN, 5});
    queue_tri('{0, 0, 0, ONE, 0, 0, 0, ONE, 0});
    queue_tri('{0, 0, 0, ONE, 0, 0, -ONE, ONE, 0});
    queue_tri('{0, 0, 0, 3 * ONE, 0, 0, 6 * ONE, 0, 0});
    queue_tri('{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX});
    queue_tri('{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN, CMAX});
    queue_tri('{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN});
    queue_tri('{CMAX, 0, 0, CMIN, 0, 0, CMAX, CMAX, CMIN});
    queue_tri('{0, 0, 0, 1, 0, 0, 0, 0, 1});
    queue_tri('{0, 0, 0, 1, 1, 1, -1, -1, -1});
    queue_tri('{-1, -1, -1, -1, -1, -1, 0, 0, 0});
    queue_tri('{0, 0, 0, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN});
    wait_drained();

    // Each scale setting gets a run of random triangles; the sender holds
    // off between settings until every expected result has come back.
    for (int ph = 0; ph < 6; ph++) begin
      write_scale(scales[ph]);
      if (ph == 5) quiet = 1'b1;
      queue_random(ph == 0 ? 400 : 220);
      wait_drained();
    end
    write_scale($urandom);
    queue_random(100);
    wait_drained();

    $display("Checked %0d flattened triangles over 8 scale settings", n_checked);
    $display("(%0d with a collapsed first edge, %0d at the saturation limit).",
             n_degen, n_sat);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout: stream stopped moving.");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
design/trpr_pkg.sv
design/trpr_mul.sv
design/trpr_root.sv
design/triangle_planar_rest_coords_core.sv
tb/tb_top.sv
